### design/lexicographic_permutation_generator_top_defines.svh
// Assertion macros used by the permutation generator controller.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef LEXICOGRAPHIC_PERMUTATION_GENERATOR_TOP_DEFINES_SVH
`define LEXICOGRAPHIC_PERMUTATION_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define LPG_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpg assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LPG_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpg assertion failed");

`endif

### design/lpg_pkg.sv
// Package of the permutation generator: widths, reset constants, state and
// operation codes, and the command and status structs. No dependencies.
package lpg_pkg;

   localparam int DEFAULT_MAX_LENGTH = 16;
   localparam int ELEM_W = 5;
   localparam int POS_W = 4;
   localparam int CSR_W = 5;
   localparam logic [CSR_W-1:0] LENGTH_RESET = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_PIV_RD,
      ST_PIV_CMP,
      ST_SUC_RD,
      ST_SUC_CMP,
      ST_SWAP_P,
      ST_SWAP_Q,
      ST_REV_RD,
      ST_REV_LO,
      ST_REV_HI,
      ST_EMIT_RD,
      ST_EMIT_OUT,
      ST_EXHAUST
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT_START,
      OP_INIT_WRITE,
      OP_PIV_START,
      OP_PIV_READ,
      OP_PIV_NEXT,
      OP_PIV_FOUND,
      OP_SUC_READ,
      OP_SUC_NEXT,
      OP_SWAP_P,
      OP_SWAP_Q,
      OP_REV_READ,
      OP_REV_LO,
      OP_REV_HI,
      OP_EMIT_START,
      OP_EMIT_READ,
      OP_EMIT_NEXT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   show_exh;
   } cmd_type;

   typedef struct packed {
      logic lt;
      logic gt;
      logic a_is_last;
      logic a_is_one;
      logic a_lt_b;
      logic len_is_one;
   } status_type;

endpackage

### design/lpg_if.sv
// Handshake interfaces of the permutation generator: request, response and
// register write channels. Depends on lpg_pkg for the payload widths.
interface lpg_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface lpg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpg_pkg::POS_W-1:0]   position;
   logic [lpg_pkg::ELEM_W-1:0]  element;
   logic                        last;
   logic                        exhausted;

   modport source (output valid, output position, output element, output last,
                   output exhausted, input ready);
   modport sink (input valid, input position, input element, input last,
                 input exhausted, output ready);
endinterface

interface lpg_csr_if;
   logic                       valid;
   logic                       ready;
   logic [lpg_pkg::CSR_W-1:0]  perm_length;

   modport source (output valid, output perm_length, input ready);
   modport sink (input valid, input perm_length, output ready);
endinterface

### design/lpg_ctrl.sv
// Controller of the permutation generator: sequences initialisation, pivot and successor
// search, swap, suffix reversal, emission and the exhausted reply. Depends on lpg_pkg and the defines header.
`include "lexicographic_permutation_generator_top_defines.svh"

module lpg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_restart,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  lpg_pkg::status_type status,
   output lpg_pkg::cmd_type    cmd
);

   lpg_pkg::state_type state_ff, state_in;
   logic first_pending_ff, first_pending_in;
   logic req_fire;

   assign req_fire = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpg_pkg::ST_IDLE;
         first_pending_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         first_pending_ff <= first_pending_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      first_pending_in = first_pending_ff;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_restart || first_pending_ff) begin
                  state_in = lpg_pkg::ST_INIT;
                  first_pending_in = 1'b0;
               end else if (status.len_is_one) begin
                  state_in = lpg_pkg::ST_EXHAUST;
               end else begin
                  state_in = lpg_pkg::ST_PIV_RD;
               end
            end
         end
         lpg_pkg::ST_INIT: begin
            if (status.a_is_last) state_in = lpg_pkg::ST_EMIT_RD;
         end
         lpg_pkg::ST_PIV_RD: state_in = lpg_pkg::ST_PIV_CMP;
         lpg_pkg::ST_PIV_CMP: begin
            if (status.lt) state_in = lpg_pkg::ST_SUC_RD;
            else if (status.a_is_one) state_in = lpg_pkg::ST_EXHAUST;
            else state_in = lpg_pkg::ST_PIV_RD;
         end
         lpg_pkg::ST_SUC_RD: state_in = lpg_pkg::ST_SUC_CMP;
         lpg_pkg::ST_SUC_CMP: begin
            if (status.gt) state_in = lpg_pkg::ST_SWAP_P;
            else state_in = lpg_pkg::ST_SUC_RD;
         end
         lpg_pkg::ST_SWAP_P: state_in = lpg_pkg::ST_SWAP_Q;
         lpg_pkg::ST_SWAP_Q: state_in = lpg_pkg::ST_REV_RD;
         lpg_pkg::ST_REV_RD: begin
            if (status.a_lt_b) state_in = lpg_pkg::ST_REV_LO;
            else state_in = lpg_pkg::ST_EMIT_RD;
         end
         lpg_pkg::ST_REV_LO: state_in = lpg_pkg::ST_REV_HI;
         lpg_pkg::ST_REV_HI: state_in = lpg_pkg::ST_REV_RD;
         lpg_pkg::ST_EMIT_RD: state_in = lpg_pkg::ST_EMIT_OUT;
         lpg_pkg::ST_EMIT_OUT: begin
            if (rsp_ready) begin
               if (status.a_is_last) state_in = lpg_pkg::ST_IDLE;
               else state_in = lpg_pkg::ST_EMIT_RD;
            end
         end
         lpg_pkg::ST_EXHAUST: begin
            if (rsp_ready) state_in = lpg_pkg::ST_IDLE;
         end
         default: state_in = lpg_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = lpg_pkg::OP_NONE;
      cmd.show_exh = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         lpg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_restart || first_pending_ff) cmd.op = lpg_pkg::OP_INIT_START;
               else if (!status.len_is_one) cmd.op = lpg_pkg::OP_PIV_START;
            end
         end
         lpg_pkg::ST_INIT: cmd.op = lpg_pkg::OP_INIT_WRITE;
         lpg_pkg::ST_PIV_RD: cmd.op = lpg_pkg::OP_PIV_READ;
         lpg_pkg::ST_PIV_CMP: begin
            if (status.lt) cmd.op = lpg_pkg::OP_PIV_FOUND;
            else if (!status.a_is_one) cmd.op = lpg_pkg::OP_PIV_NEXT;
         end
         lpg_pkg::ST_SUC_RD: cmd.op = lpg_pkg::OP_SUC_READ;
         lpg_pkg::ST_SUC_CMP: begin
            if (!status.gt) cmd.op = lpg_pkg::OP_SUC_NEXT;
         end
         lpg_pkg::ST_SWAP_P: cmd.op = lpg_pkg::OP_SWAP_P;
         lpg_pkg::ST_SWAP_Q: cmd.op = lpg_pkg::OP_SWAP_Q;
         lpg_pkg::ST_REV_RD: begin
            if (status.a_lt_b) cmd.op = lpg_pkg::OP_REV_READ;
            else cmd.op = lpg_pkg::OP_EMIT_START;
         end
         lpg_pkg::ST_REV_LO: cmd.op = lpg_pkg::OP_REV_LO;
         lpg_pkg::ST_REV_HI: cmd.op = lpg_pkg::OP_REV_HI;
         lpg_pkg::ST_EMIT_RD: cmd.op = lpg_pkg::OP_EMIT_READ;
         lpg_pkg::ST_EMIT_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !status.a_is_last) cmd.op = lpg_pkg::OP_EMIT_NEXT;
         end
         lpg_pkg::ST_EXHAUST: begin
            rsp_valid = 1'b1;
            cmd.show_exh = 1'b1;
         end
         default: cmd.op = lpg_pkg::OP_NONE;
      endcase
   end

   `LPG_ASSERT_NOW(a_no_overlap, req_ready, !rsp_valid)
   `LPG_ASSERT_NEXT(a_first_inits, req_fire && first_pending_ff, state_ff == lpg_pkg::ST_INIT)
   `LPG_ASSERT_NEXT(a_first_cleared, req_fire, !first_pending_ff)

endmodule

### design/lpg_dp.sv
// Datapath of the permutation generator: length register, permutation store,
// index counters, comparators and response payload. Depends on lpg_pkg.
module lpg_dp #(
   parameter int MAX_LENGTH = lpg_pkg::DEFAULT_MAX_LENGTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [lpg_pkg::CSR_W-1:0]     csr_data,
   input  lpg_pkg::cmd_type              cmd,
   output lpg_pkg::status_type           status,
   output logic [lpg_pkg::POS_W-1:0]     rsp_position,
   output logic [lpg_pkg::ELEM_W-1:0]    rsp_element,
   output logic                          rsp_last,
   output logic                          rsp_exhausted
);

   localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
   localparam int LW = $clog2(MAX_LENGTH + 1);

   logic [lpg_pkg::CSR_W-1:0] perm_length_ff;
   logic [lpg_pkg::ELEM_W-1:0] perm_store_ff [MAX_LENGTH];
   logic [IW-1:0] a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [lpg_pkg::ELEM_W-1:0] piv_ff, piv_in;
   logic [lpg_pkg::ELEM_W-1:0] rd0_ff, rd1_ff;
   logic [LW-1:0] len_sat;
   logic [IW-1:0] last_idx;
   logic [IW:0] a_plus;
   logic wr_en, rd0_en, rd1_en;
   logic [IW-1:0] wr_addr, rd0_addr, rd1_addr;
   logic [lpg_pkg::ELEM_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (reset) perm_length_ff <= lpg_pkg::LENGTH_RESET;
      else if (csr_valid) perm_length_ff <= csr_data;
   end

   always_comb begin
      if (perm_length_ff == '0) len_sat = LW'(1);
      else if (32'(perm_length_ff) > MAX_LENGTH) len_sat = LW'(MAX_LENGTH);
      else len_sat = LW'(perm_length_ff);
      last_idx = IW'(len_sat - LW'(1));
      a_plus = {1'b0, a_ff} + (IW + 1)'(1);
   end

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      piv_in = piv_ff;
      wr_en = 1'b0;
      wr_addr = a_ff;
      wr_data = rd1_ff;
      rd0_en = 1'b0;
      rd1_en = 1'b0;
      rd0_addr = a_ff;
      rd1_addr = b_ff;
      unique case (cmd.op)
         lpg_pkg::OP_INIT_START: a_in = '0;
         lpg_pkg::OP_INIT_WRITE: begin
            wr_en = 1'b1;
            wr_data = lpg_pkg::ELEM_W'(a_plus);
            a_in = (a_ff == last_idx) ? '0 : IW'(a_plus);
         end
         lpg_pkg::OP_PIV_START: a_in = last_idx;
         lpg_pkg::OP_PIV_READ: begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
            rd0_addr = a_ff - IW'(1);
            rd1_addr = a_ff;
         end
         lpg_pkg::OP_PIV_NEXT: a_in = a_ff - IW'(1);
         lpg_pkg::OP_PIV_FOUND: begin
            p_in = a_ff - IW'(1);
            piv_in = rd0_ff;
            b_in = last_idx;
         end
         lpg_pkg::OP_SUC_READ: rd1_en = 1'b1;
         lpg_pkg::OP_SUC_NEXT: b_in = b_ff - IW'(1);
         lpg_pkg::OP_SWAP_P: begin
            wr_en = 1'b1;
            wr_addr = p_ff;
            wr_data = rd1_ff;
         end
         lpg_pkg::OP_SWAP_Q: begin
            wr_en = 1'b1;
            wr_addr = b_ff;
            wr_data = piv_ff;
            a_in = p_ff + IW'(1);
            b_in = last_idx;
         end
         lpg_pkg::OP_REV_READ: begin
            rd0_en = 1'b1;
            rd1_en = 1'b1;
         end
         lpg_pkg::OP_REV_LO: begin
            wr_en = 1'b1;
            wr_addr = a_ff;
            wr_data = rd1_ff;
         end
         lpg_pkg::OP_REV_HI: begin
            wr_en = 1'b1;
            wr_addr = b_ff;
            wr_data = rd0_ff;
            a_in = IW'(a_plus);
            b_in = b_ff - IW'(1);
         end
         lpg_pkg::OP_EMIT_START: a_in = '0;
         lpg_pkg::OP_EMIT_READ: rd0_en = 1'b1;
         lpg_pkg::OP_EMIT_NEXT: a_in = IW'(a_plus);
         default: a_in = a_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      piv_ff <= piv_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) perm_store_ff[wr_addr] <= wr_data;
      if (rd0_en) rd0_ff <= perm_store_ff[rd0_addr];
      if (rd1_en) rd1_ff <= perm_store_ff[rd1_addr];
   end

   always_comb begin
      status.lt = rd0_ff < rd1_ff;
      status.gt = rd1_ff > piv_ff;
      status.a_is_last = a_ff == last_idx;
      status.a_is_one = a_ff == IW'(1);
      status.a_lt_b = a_ff < b_ff;
      status.len_is_one = last_idx == '0;
   end

   always_comb begin
      rsp_exhausted = cmd.show_exh;
      rsp_last = cmd.show_exh || (a_ff == last_idx);
      rsp_position = cmd.show_exh ? '0 : lpg_pkg::POS_W'(a_ff);
      rsp_element = cmd.show_exh ? '0 : rd0_ff;
   end

endmodule

### design/lexicographic_permutation_generator_top.sv
// Lexicographic permutation generator, L = effective length. One request at a time.
// Restart or first request: L store writes of the identity, then each element is emitted.
// Advance: pivot scan and successor scan step by step, the swap, the suffix reversal
// pair by pair, then emission of each element; with no pivot the reply is exhausted.
// Reset is synchronous: length returns to 16 and the store is not cleared.
module lexicographic_permutation_generator_top #(
   parameter int MAX_LENGTH = lpg_pkg::DEFAULT_MAX_LENGTH
) (
   input  logic      clock,
   input  logic      reset,
   lpg_req_if.sink   req_ch,
   lpg_rsp_if.source rsp_ch,
   lpg_csr_if.sink   csr_ch
);

   lpg_pkg::cmd_type    cmd;
   lpg_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   lpg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .status      (status),
      .cmd         (cmd)
   );

   lpg_dp #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_ch.valid),
      .csr_data      (csr_ch.perm_length),
      .cmd           (cmd),
      .status        (status),
      .rsp_position  (rsp_ch.position),
      .rsp_element   (rsp_ch.element),
      .rsp_last      (rsp_ch.last),
      .rsp_exhausted (rsp_ch.exhausted)
   );

endmodule

### tb/testbench.sv
// Self-checking testbench for lexicographic_permutation_generator_top.
// Drives random and directed requests and length writes, predicts every result in a
// scoreboard class and compares it field by field. Depends on lpg_pkg and lpg_if.sv.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LEN = lpg_pkg::DEFAULT_MAX_LENGTH;
   localparam int POS_W = lpg_pkg::POS_W;
   localparam int ELEM_W = lpg_pkg::ELEM_W;
   localparam int CSR_W = lpg_pkg::CSR_W;
   localparam logic [CSR_W-1:0] LENGTH_RESET = lpg_pkg::LENGTH_RESET;
   localparam int RANDOM_ITEMS = 250;

   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [ELEM_W-1:0] element;
      logic              last;
      logic              exhausted;
   } perm_result_type;

   class perm_scoreboard;
      perm_result_type   expected_q[$];
      logic [ELEM_W-1:0] perm_state[MAX_LEN];
      logic [CSR_W-1:0]  length_reg;
      bit                identity_due;
      int                failures;
      int                checked;

      function new();
         foreach (perm_state[i]) perm_state[i] = '0;
         length_reg = LENGTH_RESET;
         identity_due = 1'b1;
         failures = 0;
         checked = 0;
      endfunction

      function int active_length();
         int n;
         n = length_reg;
         if (n < 1) n = 1;
         if (n > MAX_LEN) n = MAX_LEN;
         return n;
      endfunction

      function void set_length(logic [CSR_W-1:0] value);
         length_reg = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void swap_entries(int a, int b);
         logic [ELEM_W-1:0] tmp;
         tmp = perm_state[a];
         perm_state[a] = perm_state[b];
         perm_state[b] = tmp;
      endfunction

      // Steps the held permutation forward; returns 0 when it is already descending.
      function bit advance_perm(int n);
         int pivot;
         int succ;
         int lo;
         int hi;
         bit found;
         found = 1'b0;
         pivot = 0;
         for (int i = n - 1; i >= 1 && !found; i--) begin
            if (perm_state[i-1] < perm_state[i]) begin
               pivot = i - 1;
               found = 1'b1;
            end
         end
         if (!found) return 1'b0;
         succ = n - 1;
         while (perm_state[succ] <= perm_state[pivot]) succ--;
         swap_entries(pivot, succ);
         lo = pivot + 1;
         hi = n - 1;
         while (lo < hi) begin
            swap_entries(lo, hi);
            lo++;
            hi--;
         end
         return 1'b1;
      endfunction

      function void note_request(bit restart_bit);
         int n;
         perm_result_type r;
         n = active_length();
         if (restart_bit || identity_due) begin
            for (int i = 0; i < n; i++) perm_state[i] = ELEM_W'(i + 1);
            identity_due = 1'b0;
         end else if (!advance_perm(n)) begin
            r.position = '0;
            r.element = '0;
            r.last = 1'b1;
            r.exhausted = 1'b1;
            expected_q.push_back(r);
            return;
         end
         for (int i = 0; i < n; i++) begin
            r.position = POS_W'(i);
            r.element = perm_state[i];
            r.last = (i == n - 1);
            r.exhausted = 1'b0;
            expected_q.push_back(r);
         end
      endfunction

      task report_mismatch(string msg);
         failures++;
         $display("%0t ns: MISMATCH %s", $time, msg);
      endtask

      task check_result(perm_result_type got);
         perm_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: pos %0d elem %0d",
                                      got.position, got.element));
            return;
         end
         want = expected_q.pop_front();
         if (got.position !== want.position)
            report_mismatch($sformatf("result %0d position: got %0d, expected %0d",
                                      checked, got.position, want.position));
         if (got.element !== want.element)
            report_mismatch($sformatf("result %0d element: got %0d, expected %0d",
                                      checked, got.element, want.element));
         if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last: got %0b, expected %0b",
                                      checked, got.last, want.last));
         if (got.exhausted !== want.exhausted)
            report_mismatch($sformatf("result %0d exhausted: got %0b, expected %0b",
                                      checked, got.exhausted, want.exhausted));
         checked++;
      endtask
   endclass

   logic clock;
   logic reset;

   lpg_req_if req_bus();
   lpg_rsp_if rsp_bus();
   lpg_csr_if csr_bus();

   perm_scoreboard sb;

   lexicographic_permutation_generator_top #(
      .MAX_LENGTH(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_bus),
      .rsp_ch(rsp_bus),
      .csr_ch(csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("lexicographic_permutation_generator_top verification failed");
      $finish;
   end

   // Mostly no gap or a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic issue_request(bit restart_bit, bit more);
      int gap;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.restart <= restart_bit;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sb.note_request(restart_bit);
      gap = pick_gap();
      if (!more && gap == 0) gap = 1;
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         req_bus.restart <= 1'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_length(logic [CSR_W-1:0] value);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.perm_length <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      sb.set_length(value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      csr_bus.perm_length <= CSR_W'($urandom);
   endtask

   // A negative length leaves the register as it stands; a '1' in the pattern is a restart.
   task automatic directed_phase(int length, string pattern);
      if (length >= 0) write_length(CSR_W'(length));
      for (int k = 0; k < pattern.len(); k++)
         issue_request(pattern[k] == "1", k != pattern.len() - 1);
   endtask

   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(0, 24)) @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         sb.check_result({rsp_bus.position, rsp_bus.element, rsp_bus.last, rsp_bus.exhausted});
   end

   initial begin
      int issued;
      int n;
      int count;
      int r;
      logic [CSR_W-1:0] len_pick;
      bit restart_bit;

      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.restart = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.perm_length = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // The first request runs at the full reset length, so every entry is written
      // before any later length change without a restart can read it.
      directed_phase(-1, "0001");
      directed_phase(1, "00100");
      directed_phase(0, "10");
      directed_phase(2, "0010");
      directed_phase(31, "01");
      directed_phase(17, "0");
      directed_phase(3, "1000000");

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 45) len_pick = CSR_W'($urandom_range(1, 4));
         else if (r < 75) len_pick = CSR_W'($urandom_range(5, 8));
         else if (r < 90) len_pick = CSR_W'($urandom_range(9, 16));
         else if (r < 95) len_pick = CSR_W'($urandom_range(17, 31));
         else len_pick = '0;
         write_length(len_pick);
         n = sb.active_length();
         count = $urandom_range(2, 12);
         if (n <= 4 && $urandom_range(0, 1) == 1) begin
            count = 1;
            for (int k = 2; k <= n; k++) count *= k;
            count += $urandom_range(1, 3);
         end
         for (int j = 0; j < count; j++) begin
            if (j == 0) restart_bit = ($urandom_range(0, 9) < 7);
            else restart_bit = ($urandom_range(0, 99) < 6);
            issue_request(restart_bit, j != count - 1);
            issued++;
         end
      end

      for (int w = 0; w < 50000 && sb.pending() != 0; w++) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

      if (sb.failures == 0) begin
         $display("lexicographic_permutation_generator_top verification clean");
      end else begin
         $display("lexicographic_permutation_generator_top verification failed");
      end
      $finish;
   end
endmodule
